// ----- rtl/core/sffd_pkg.sv -----
// Shared constants and types for the stereo fractional feedback delay unit.
// No dependencies; used by the interfaces and the top level.
`default_nettype none

package sffd_pkg;

	localparam int DEPTH      = 65536;
	localparam int AW         = $clog2(DEPTH);
	localparam int SAMPLE_W   = 24;
	localparam int FRAC_W     = 8;
	localparam int DELAY_W    = 24;
	localparam int GAIN_W     = 15;
	localparam int GAIN_FRAC  = 15;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;

	localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(16776959);
	localparam logic [GAIN_W-1:0]  GAIN_RESET  = '0;

	// shared multiplier: sample times a small unsigned coefficient
	localparam int MUL_B_W = GAIN_W + 1;
	localparam int PROD_W  = SAMPLE_W + MUL_B_W;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		sample_t left;
		sample_t right;
	} frame_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DELAY = 1'b0,
		CFG_GAIN  = 1'b1
	} cfg_reg_t;

endpackage

`default_nettype wire

// ----- rtl/core/sffd_if.sv -----
// Valid/ready channels for the delay unit: dry frames in, wet frames out.
// Depends on sffd_pkg.
`default_nettype none

interface sffd_in_if;
	logic              valid;
	logic              ready;
	sffd_pkg::sample_t left_in;
	sffd_pkg::sample_t right_in;

	modport source (output valid, output left_in, output right_in, input ready);
	modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface sffd_out_if;
	logic              valid;
	logic              ready;
	sffd_pkg::sample_t left_out;
	sffd_pkg::sample_t right_out;

	modport source (output valid, output left_out, output right_out, input ready);
	modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/stereo_fractional_feedback_delay_unit.sv -----
// Stereo fractional delay line with feedback and linear interpolation.
// Depends on sffd_pkg and the channel interfaces in sffd_if.sv.
//
//  channel | kind          | word
//  --------+---------------+------------------------------------------
//  dry     | valid/ready in| left_in, right_in (24-bit signed)
//  wet     | valid/ready out| left_out, right_out (24-bit signed)
//  cfg     | write only    | cfg_we, cfg_index (0 delay, 1 gain), cfg_data
//
// A word is accepted only in idle, and the next only after its write-back: two store reads,
// then per channel two interpolation products, a sum, the gain product and the
// feedback add, all through one shared 24x16 multiplier, then the write-back.
// After reset the store is cleared one entry a cycle, all 65536 entries, dry not ready.
// The write-back cycle waits while the wet output register is full and not taken.
`default_nettype none

module stereo_fractional_feedback_delay_unit (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire [sffd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [sffd_pkg::CFG_DATA_W-1:0]      cfg_data,
	sffd_in_if.sink                             dry,
	sffd_out_if.source                          wet
);

	localparam int NW = sffd_pkg::DELAY_W - sffd_pkg::FRAC_W;
	localparam logic signed [sffd_pkg::PROD_W-1:0] ROUND_Y =
		sffd_pkg::PROD_W'(1 << (sffd_pkg::FRAC_W - 1));
	localparam logic signed [sffd_pkg::PROD_W-1:0] ROUND_FB =
		sffd_pkg::PROD_W'(1 << (sffd_pkg::GAIN_FRAC - 1));
	localparam logic [sffd_pkg::FRAC_W:0] FRAC_ONE =
		(sffd_pkg::FRAC_W + 1)'(1 << sffd_pkg::FRAC_W);
	localparam logic [sffd_pkg::AW-1:0] LAST_ADDR = {sffd_pkg::AW{1'b1}};
	localparam logic signed [sffd_pkg::SAMPLE_W-1:0] SAMPLE_MAX =
		{1'b0, {(sffd_pkg::SAMPLE_W - 1){1'b1}}};
	localparam logic signed [sffd_pkg::SAMPLE_W-1:0] SAMPLE_MIN =
		{1'b1, {(sffd_pkg::SAMPLE_W - 1){1'b0}}};

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_A,
		ST_RD_B,
		ST_GET_B,
		ST_MUL_A,
		ST_MUL_B,
		ST_SUM,
		ST_MUL_G,
		ST_FB,
		ST_WRITE
	} state_t;

	state_t                          state_q;
	logic [sffd_pkg::DELAY_W-1:0]    delay_q;
	logic [sffd_pkg::GAIN_W-1:0]     gain_q;
	logic [sffd_pkg::AW-1:0]         wp_q;
	logic [sffd_pkg::AW-1:0]         ra_q;
	logic                            zero_n_q;
	logic                            ch_q;
	logic                            out_valid_q;

	// datapath
	sffd_pkg::frame_t                mem [sffd_pkg::DEPTH];
	sffd_pkg::frame_t                rd_q;
	sffd_pkg::sample_t               x_q [2];
	sffd_pkg::sample_t               a_q [2];
	sffd_pkg::sample_t               b_q [2];
	sffd_pkg::sample_t               y_q [2];
	sffd_pkg::sample_t               s_q [2];
	sffd_pkg::sample_t               out_left_q;
	sffd_pkg::sample_t               out_right_q;
	logic signed [sffd_pkg::PROD_W-1:0] prod_q;
	logic signed [sffd_pkg::PROD_W-1:0] acc_q;

	logic                            accept;
	logic                            out_free;
	logic [NW-1:0]                   n_raw;
	logic [NW-1:0]                   n_clamped;
	logic [sffd_pkg::FRAC_W-1:0]     frac;
	logic [sffd_pkg::AW-1:0]         rd_addr;
	logic                            mem_we;
	logic [sffd_pkg::AW-1:0]         wr_addr;
	sffd_pkg::frame_t                wr_data;
	sffd_pkg::sample_t               mul_a;
	logic signed [sffd_pkg::MUL_B_W-1:0] mul_b;
	logic signed [sffd_pkg::PROD_W-1:0]  interp_sum;
	logic signed [sffd_pkg::PROD_W-1:0]  fb_sum;
	sffd_pkg::sample_t               fb_term;
	logic signed [sffd_pkg::SAMPLE_W:0] store_sum;
	sffd_pkg::sample_t               store_sat;

	assign accept   = dry.valid && dry.ready;
	assign out_free = !out_valid_q || wet.ready;

	assign dry.ready     = (state_q == ST_IDLE);
	assign wet.valid     = out_valid_q;
	assign wet.left_out  = out_left_q;
	assign wet.right_out = out_right_q;

	// integer delay clamped so both taps stay older than or equal to the new frame
	assign n_raw     = delay_q[sffd_pkg::DELAY_W-1:sffd_pkg::FRAC_W];
	assign n_clamped = (32'(n_raw) > 32'(sffd_pkg::DEPTH - 2)) ?
		NW'(sffd_pkg::DEPTH - 2) : n_raw;
	assign frac      = delay_q[sffd_pkg::FRAC_W-1:0];

	assign rd_addr = (state_q == ST_RD_A) ? ra_q : ra_q + 1'b1;

	assign mem_we  = (state_q == ST_CLEAR) || (state_q == ST_WRITE && out_free);
	assign wr_addr = wp_q;
	assign wr_data = (state_q == ST_CLEAR) ? '0 :
		sffd_pkg::frame_t'{left: s_q[0], right: s_q[1]};

	always_comb begin
		mul_a = a_q[ch_q];
		mul_b = $signed(sffd_pkg::MUL_B_W'(frac));
		case (state_q)
			ST_MUL_B: begin
				mul_a = b_q[ch_q];
				mul_b = $signed(sffd_pkg::MUL_B_W'(FRAC_ONE - (sffd_pkg::FRAC_W + 1)'(frac)));
			end
			ST_MUL_G: begin
				mul_a = y_q[ch_q];
				mul_b = $signed(sffd_pkg::MUL_B_W'(gain_q));
			end
			default: begin
				mul_a = a_q[ch_q];
				mul_b = $signed(sffd_pkg::MUL_B_W'(frac));
			end
		endcase
	end

	// floor shifts are plain part-selects of the two's complement sums
	assign interp_sum = acc_q + prod_q + ROUND_Y;
	assign fb_sum     = prod_q + ROUND_FB;
	assign fb_term    = fb_sum[sffd_pkg::GAIN_FRAC +: sffd_pkg::SAMPLE_W];
	assign store_sum  = {x_q[ch_q][sffd_pkg::SAMPLE_W-1], x_q[ch_q]} +
		{fb_term[sffd_pkg::SAMPLE_W-1], fb_term};

	always_comb begin
		if (store_sum[sffd_pkg::SAMPLE_W] != store_sum[sffd_pkg::SAMPLE_W-1]) begin
			store_sat = store_sum[sffd_pkg::SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX;
		end else begin
			store_sat = store_sum[sffd_pkg::SAMPLE_W-1:0];
		end
	end

	// line store: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			delay_q     <= sffd_pkg::DELAY_RESET;
			gain_q      <= sffd_pkg::GAIN_RESET;
			wp_q        <= '0;
			ra_q        <= '0;
			zero_n_q    <= 1'b0;
			ch_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					sffd_pkg::CFG_DELAY: delay_q <= cfg_data[sffd_pkg::DELAY_W-1:0];
					sffd_pkg::CFG_GAIN:  gain_q  <= cfg_data[sffd_pkg::GAIN_W-1:0];
					default: ;
				endcase
			end
			// write-back sets the flag itself, so only clear it elsewhere
			if (out_valid_q && wet.ready && state_q != ST_WRITE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					// write pointer doubles as the sweep address and wraps back to zero
					wp_q <= wp_q + 1'b1;
					if (wp_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						ra_q     <= wp_q - sffd_pkg::AW'(n_clamped) - 1'b1;
						zero_n_q <= (n_clamped == '0);
						ch_q     <= 1'b0;
						state_q  <= ST_RD_A;
					end
				end
				ST_RD_A:  state_q <= ST_RD_B;
				ST_RD_B:  state_q <= ST_GET_B;
				ST_GET_B: state_q <= ST_MUL_A;
				ST_MUL_A: state_q <= ST_MUL_B;
				ST_MUL_B: state_q <= ST_SUM;
				ST_SUM:   state_q <= ST_MUL_G;
				ST_MUL_G: state_q <= ST_FB;
				ST_FB: begin
					if (ch_q) begin
						state_q <= ST_WRITE;
					end else begin
						ch_q    <= 1'b1;
						state_q <= ST_MUL_A;
					end
				end
				ST_WRITE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						wp_q        <= wp_q + 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (accept) begin
			x_q[0] <= dry.left_in;
			x_q[1] <= dry.right_in;
		end
		if (state_q == ST_RD_B) begin
			a_q[0] <= rd_q.left;
			a_q[1] <= rd_q.right;
		end
		if (state_q == ST_GET_B) begin
			// zero integer delay: newer tap is the frame being written
			b_q[0] <= zero_n_q ? x_q[0] : rd_q.left;
			b_q[1] <= zero_n_q ? x_q[1] : rd_q.right;
		end
		if (state_q == ST_MUL_B) begin
			acc_q <= prod_q;
		end
		if (state_q == ST_SUM) begin
			y_q[ch_q] <= interp_sum[sffd_pkg::FRAC_W +: sffd_pkg::SAMPLE_W];
		end
		if (state_q == ST_FB) begin
			s_q[ch_q] <= store_sat;
		end
		if (state_q == ST_WRITE && out_free) begin
			out_left_q  <= y_q[0];
			out_right_q <= y_q[1];
		end
	end

	a_accept_starts_read: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_RD_A)
		else $error("accepted word did not start the store read");

	a_wet_from_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_WRITE))
		else $error("wet word raised outside write-back");

	a_wp_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE && out_free) |=> wp_q == $past(wp_q) + 1'b1)
		else $error("write pointer did not advance on write-back");

	a_taps_miss_wp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD_A) |-> (ra_q != wp_q))
		else $error("older tap addresses the frame being written");

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Testbench for stereo_fractional_feedback_delay_unit: drives dry words,
// predicts the interpolated and fed-back wet words, and checks each of them.
// Depends on sffd_pkg, sffd_if.sv and the top level of the unit.

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sffd_pkg::*;

	localparam int     STALL_LIMIT   = 4 * DEPTH;
	localparam int     LATENCY_SLACK = 20;
	localparam int     HOLD_CYCLES   = 400;
	localparam longint ONE           = longint'(1) << FRAC_W;
	localparam longint SAMPLE_MAX    = (longint'(1) << (SAMPLE_W - 1)) - 1;
	localparam longint SAMPLE_MIN    = -(longint'(1) << (SAMPLE_W - 1));

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_reg_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sffd_in_if  dry ();
	sffd_out_if wet ();

	stereo_fractional_feedback_delay_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.dry       (dry),
		.wet       (wet)
	);

	// predictor state: its own copy of the line store and registers
	sample_t         line_store [2][DEPTH];
	logic [AW-1:0]   wr_ptr;
	int unsigned     delay_q8;
	longint          gain_q15;
	frame_t          wet_expect [$];
	frame_t          wet_want;

	int              mismatches  = 0;
	int              idle_cycles = 0;
	int              src_idle_pct  = 0;
	int              sink_idle_pct = 0;
	bit              hold_active = 1'b0;
	event            hold_off_go;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// one store write, two neighbouring reads, blend, then feedback into the new entry
	function automatic frame_t delayed_frame(input frame_t dry_word);
		int unsigned   lag;
		logic [AW-1:0] ra;
		logic [AW-1:0] rb;
		longint        frac;
		longint        mix;
		longint        fb;
		longint        fed;
		sample_t       x [2];
		sample_t       y [2];
		x[0] = dry_word.left;
		x[1] = dry_word.right;
		lag = delay_q8 >> FRAC_W;
		if (lag > DEPTH - 2)
			lag = DEPTH - 2;
		frac = longint'(delay_q8 & (ONE - 1));
		ra = wr_ptr - AW'(lag) - 1'b1;
		rb = ra + 1'b1;
		for (int ch = 0; ch < 2; ch++)
			line_store[ch][wr_ptr] = x[ch];
		for (int ch = 0; ch < 2; ch++) begin
			mix = (longint'(line_store[ch][ra]) * frac
				+ longint'(line_store[ch][rb]) * (ONE - frac) + ONE / 2) >>> FRAC_W;
			fb = (mix * gain_q15 + (longint'(1) << (GAIN_FRAC - 1))) >>> GAIN_FRAC;
			fed = longint'(line_store[ch][wr_ptr]) + fb;
			if (fed > SAMPLE_MAX)
				fed = SAMPLE_MAX;
			else if (fed < SAMPLE_MIN)
				fed = SAMPLE_MIN;
			line_store[ch][wr_ptr] = sample_t'(fed);
			y[ch] = sample_t'(mix);
		end
		wr_ptr = wr_ptr + 1'b1;
		return '{left: y[0], right: y[1]};
	endfunction

	function automatic sample_t rand_sample();
		case ($urandom_range(9))
			0: return sample_t'(SAMPLE_MAX);
			1: return sample_t'(SAMPLE_MIN);
			2: return sample_t'(int'($urandom_range(16)) - 8);
			default: return sample_t'($urandom());
		endcase
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_frame(input sample_t l, input sample_t r);
		while ($urandom_range(99) < src_idle_pct) begin
			dry.valid <= 1'b0;
			@(negedge clk);
		end
		dry.valid    <= 1'b1;
		dry.left_in  <= l;
		dry.right_in <= r;
		@(posedge clk);
		while (!dry.ready)
			@(posedge clk);
		wet_expect.push_back(delayed_frame('{left: l, right: r}));
		@(negedge clk);
	endtask

	// stop offering, let every expected word arrive, then allow for the write-back
	task automatic settle();
		dry.valid <= 1'b0;
		while (wet_expect.size() != 0)
			@(negedge clk);
		repeat (LATENCY_SLACK) @(negedge clk);
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] delay_word,
			input logic [CFG_DATA_W-1:0] gain_word);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_DELAY;
		cfg_data  <= delay_word;
		@(negedge clk);
		cfg_index <= CFG_GAIN;
		cfg_data  <= gain_word;
		@(negedge clk);
		cfg_we <= 1'b0;
		delay_q8 = delay_word;
		gain_q15 = longint'(gain_word[GAIN_W-1:0]);
	endtask

	task automatic test_reset_settings();
		send_frame(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN));
		send_frame(-24'sd1, 24'sd0);
		send_frame(rand_sample(), rand_sample());
	endtask

	task automatic test_zero_delay_feedback();
		// whole delay zero, no fraction: the word just written comes straight back,
		// and full gain drives the store into saturation; top gain bits must be dropped
		configure(24'h000000, 24'hFFFFFF);
		send_frame(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN));
		send_frame(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN));
		send_frame(-24'sd1, 24'sd1);
		send_frame(24'sd0, 24'sd0);
		// half way between the previous word and the new one
		configure(24'h000080, 24'h004000);
		send_frame(sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MAX));
		send_frame(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN));
		send_frame(24'sd1, -24'sd1);
		send_frame(24'sd0, 24'sd0);
	endtask

	task automatic test_delay_extremes();
		configure(24'hFFFFFF, 24'h007FFF);	// whole part clamped to two below the store size
		repeat (3) send_frame(rand_sample(), rand_sample());
		configure(24'h0001FF, 24'h000001);
		send_frame(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MAX));
		send_frame(sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MIN));
		send_frame(rand_sample(), rand_sample());
		configure(24'h000300, 24'h000000);
		repeat (3) send_frame(rand_sample(), rand_sample());
	endtask

	task automatic test_random_traffic();
		logic [DELAY_W-1:0] delay_word;
		logic [GAIN_W-1:0]  gain;
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					src_idle_pct  = 10;
					sink_idle_pct = 83;
				end
				1: begin
					src_idle_pct  = 83;
					sink_idle_pct = 10;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
			endcase
			for (int phase = 0; phase < 3; phase++) begin
				// mostly short delays so the feedback loop keeps circulating
				case ($urandom_range(7))
					0: delay_word = DELAY_W'($urandom_range(24'hFFFFFF, 24'hFFFF00));
					1: delay_word = DELAY_W'($urandom());
					2: delay_word = {8'd0, 8'($urandom_range(40)), 8'd0};
					default: delay_word = {8'd0, 8'($urandom_range(40)), 8'($urandom())};
				endcase
				case ($urandom_range(5))
					0: gain = '1;
					1: gain = '0;
					default: gain = GAIN_W'($urandom());
				endcase
				configure(delay_word, {9'($urandom()), gain});
				repeat (150) send_frame(rand_sample(), rand_sample());
			end
		end
	endtask

	task automatic test_backpressure();
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		configure({8'd0, 8'd3, 8'($urandom())}, 24'h006000);
		-> hold_off_go;
		repeat (40) send_frame(rand_sample(), rand_sample());
		settle();
		repeat (10) send_frame(rand_sample(), rand_sample());
	endtask

	// long receiver hold-off, timed on rising edges so it never races the ready update
	always begin
		@(hold_off_go);
		@(posedge clk);
		hold_active = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_active = 1'b0;
	end

	always @(negedge clk) begin
		if (hold_active)
			wet.ready <= 1'b0;
		else
			wet.ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin
		if (wet.valid && wet.ready) begin
			if (wet_expect.size() == 0) begin
				$error("wet word with nothing outstanding: left_out %0d right_out %0d",
					wet.left_out, wet.right_out);
				mismatches++;
			end else begin
				wet_want = wet_expect.pop_front();
				if (wet.left_out !== wet_want.left) begin
					$error("left_out: expected %0d, got %0d", wet_want.left, wet.left_out);
					mismatches++;
				end
				if (wet.right_out !== wet_want.right) begin
					$error("right_out: expected %0d, got %0d", wet_want.right, wet.right_out);
					mismatches++;
				end
			end
		end
	end

	// covers the store clearing pass after reset and the receiver hold-off
	always @(posedge clk) begin
		if ((dry.valid && dry.ready) || (wet.valid && wet.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_index    <= CFG_DELAY;
		cfg_data     <= '0;
		dry.valid    <= 1'b0;
		dry.left_in  <= '0;
		dry.right_in <= '0;
		foreach (line_store[c, i])
			line_store[c][i] = '0;
		wr_ptr   = '0;
		delay_q8 = DELAY_RESET;
		gain_q15 = longint'(GAIN_RESET);
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_settings();
		test_zero_delay_feedback();
		test_delay_extremes();
		test_random_traffic();
		test_backpressure();

		settle();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
